/* hw/rtl/tcbr_pkg.sv */
// shared widths, constants and the setup step codes of the triangle coverage bin rasterizer
// no dependencies
`timescale 1ns / 1ps

package tcbr_pkg;

    // field widths
    localparam int COORD_W   = 9;
    localparam int BIN_IDX_W = 5;
    localparam int COV_W     = 8;

    // pixel position on the grid, wide enough for 32 bins of 32 pixels
    localparam int PIX_W     = 10;
    // edge step, a difference of two coordinates
    localparam int COEF_W    = COORD_W + 1;
    // pixel minus vertex
    localparam int OFS_W     = PIX_W + 1;
    localparam int PROD_W    = COEF_W + OFS_W;
    // edge function accumulator, bounded by two products plus the denominator
    localparam int EDGE_W    = 24;

    // coverage scale: count * 255 / 256
    localparam int FRAC_SHIFT = 8;
    localparam int COV_MAX    = 255;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [OFS_W-1:0]  t_ofs;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [EDGE_W-1:0] t_edge;

    // multiply-accumulate steps of the setup phase
    typedef enum logic [2:0] {
        STEP_D_X  = 3'd0,
        STEP_D_Y  = 3'd1,
        STEP_EA_X = 3'd2,
        STEP_EA_Y = 3'd3,
        STEP_EB_X = 3'd4,
        STEP_EB_Y = 3'd5,
        STEP_EC   = 3'd6
    } t_setup_step;

endpackage

/* hw/rtl/triangle_coverage_bin_rasterizer.sv */
// triangle coverage of one output bin: setup through a shared multiplier, then an
// incremental edge walk over every pixel of the bin, one pixel per cycle
// depends on tcbr_pkg
//
// usage
//   input channel: i_in_valid / o_in_stall carries three vertices and a bin column and
//   row; a transaction is taken on a rising edge with i_in_valid high and o_in_stall low
//   output channel: o_out_valid / i_out_stall carries o_coverage, the number of covered
//   pixels of the bin scaled by 255/256 and saturated to 8 bits
//   sequence: accept, then the setup steps on the shared 10x11 multiplier (denominator and
//   the edge functions a and b at the bin corner, then edge c from those), then the scan
//   of every pixel of the bin with one pixel per cycle, then the result is loaded into the
//   output register and o_out_valid rises
//   a new transaction is taken only once the current one is through: o_in_stall stays
//   high from accept until the result is loaded into the output register
//   the output register is separate from the scan, so a new transaction can be accepted
//   while a result still waits; if the receiver stalls and a second result is ready,
//   the block holds in its finish state until the first one is taken
//   degenerate triangles and bins off the grid still take the full scan and give zero
//   reset (synchronous, active low) returns to idle and empties the output register
`timescale 1ns / 1ps

module triangle_coverage_bin_rasterizer #(
    parameter int PIXELS_PER_SIDE = 400,
    parameter int BIN_SIZE        = 16,
    parameter int BINS_PER_SIDE   = 25
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [tcbr_pkg::COORD_W-1:0]    i_vertex_a_x,
    input  logic [tcbr_pkg::COORD_W-1:0]    i_vertex_a_y,
    input  logic [tcbr_pkg::COORD_W-1:0]    i_vertex_b_x,
    input  logic [tcbr_pkg::COORD_W-1:0]    i_vertex_b_y,
    input  logic [tcbr_pkg::COORD_W-1:0]    i_vertex_c_x,
    input  logic [tcbr_pkg::COORD_W-1:0]    i_vertex_c_y,
    input  logic [tcbr_pkg::BIN_IDX_W-1:0]  i_bin_col,
    input  logic [tcbr_pkg::BIN_IDX_W-1:0]  i_bin_row,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tcbr_pkg::COV_W-1:0]      o_coverage
);

    localparam int CNT_W   = (BIN_SIZE > 1) ? $clog2(BIN_SIZE) : 1;
    localparam int COUNT_W = $clog2(BIN_SIZE * BIN_SIZE + 1);
    localparam int SCALE_W = COUNT_W + tcbr_pkg::FRAC_SHIFT;
    localparam int BCMP_W  = tcbr_pkg::BIN_IDX_W + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                         r_state;
    tcbr_pkg::t_setup_step          r_step;

    // vertex c and the bin corner, kept for the offsets of the setup phase
    logic [tcbr_pkg::COORD_W-1:0]   r_cx;
    logic [tcbr_pkg::COORD_W-1:0]   r_cy;
    logic [tcbr_pkg::PIX_W-1:0]     r_px0;
    logic [tcbr_pkg::PIX_W-1:0]     r_py0;
    logic                           r_bin_ok;

    // edge steps: x step and y step of each edge function
    tcbr_pkg::t_coef                r_ka_x;     // by - cy
    tcbr_pkg::t_coef                r_ka_y;     // cx - bx
    tcbr_pkg::t_coef                r_kb_x;     // cy - ay
    tcbr_pkg::t_coef                r_kb_y;     // ax - cx
    tcbr_pkg::t_coef                r_kc_x;     // ay - by
    tcbr_pkg::t_coef                r_kc_y;     // bx - ax

    tcbr_pkg::t_edge                r_d;
    tcbr_pkg::t_edge                r_ea;
    tcbr_pkg::t_edge                r_eb;
    tcbr_pkg::t_edge                r_ec;
    tcbr_pkg::t_edge                r_ea_row;
    tcbr_pkg::t_edge                r_eb_row;
    tcbr_pkg::t_edge                r_ec_row;
    logic                           r_active;

    logic [CNT_W-1:0]               r_i;
    logic [CNT_W-1:0]               r_j;
    logic [tcbr_pkg::PIX_W-1:0]     r_px;
    logic [tcbr_pkg::PIX_W-1:0]     r_py;
    logic [COUNT_W-1:0]             r_count;

    logic                           r_out_valid;
    logic [tcbr_pkg::COV_W-1:0]     r_coverage;

    // shared multiplier
    tcbr_pkg::t_coef                w_mul_a;
    tcbr_pkg::t_ofs                 w_mul_b;
    tcbr_pkg::t_prod                w_prod;
    tcbr_pkg::t_edge                w_prod_ext;
    tcbr_pkg::t_setup_step          n_step;
    tcbr_pkg::t_ofs                 w_ofs_x;
    tcbr_pkg::t_ofs                 w_ofs_y;

    logic                           w_in_accept;
    logic                           w_out_load;
    logic                           w_d_pos;
    logic                           w_inside;
    logic                           w_in_grid;
    logic                           w_row_end;
    logic                           w_last_row;

    logic [SCALE_W-1:0]             w_scaled;
    logic [SCALE_W-1:0]             w_cov_ext;
    logic [tcbr_pkg::COV_W-1:0]     w_cov;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_coverage  = r_coverage;
    assign w_in_accept = i_in_valid && (r_state == S_IDLE);
    // finish state may load only while the output register is empty or draining
    assign w_out_load  = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    // corner pixel minus vertex c
    assign w_ofs_x = $signed({1'b0, r_px0}) - $signed({2'b00, r_cx});
    assign w_ofs_y = $signed({1'b0, r_py0}) - $signed({2'b00, r_cy});

    // operand select of the setup sequencer
    always_comb begin
        w_mul_a = r_ka_x;
        w_mul_b = w_ofs_x;
        n_step  = tcbr_pkg::STEP_D_X;
        case (r_step)
            tcbr_pkg::STEP_D_X: begin
                // (by - cy) * (ax - cx)
                w_mul_a = r_ka_x;
                w_mul_b = {r_kb_y[tcbr_pkg::COEF_W-1], r_kb_y};
                n_step  = tcbr_pkg::STEP_D_Y;
            end
            tcbr_pkg::STEP_D_Y: begin
                // (cx - bx) * (ay - cy)
                w_mul_a = r_ka_y;
                w_mul_b = tcbr_pkg::OFS_W'(0) - {r_kb_x[tcbr_pkg::COEF_W-1], r_kb_x};
                n_step  = tcbr_pkg::STEP_EA_X;
            end
            tcbr_pkg::STEP_EA_X: begin
                w_mul_a = r_ka_x;
                w_mul_b = w_ofs_x;
                n_step  = tcbr_pkg::STEP_EA_Y;
            end
            tcbr_pkg::STEP_EA_Y: begin
                w_mul_a = r_ka_y;
                w_mul_b = w_ofs_y;
                n_step  = tcbr_pkg::STEP_EB_X;
            end
            tcbr_pkg::STEP_EB_X: begin
                w_mul_a = r_kb_x;
                w_mul_b = w_ofs_x;
                n_step  = tcbr_pkg::STEP_EB_Y;
            end
            tcbr_pkg::STEP_EB_Y: begin
                w_mul_a = r_kb_y;
                w_mul_b = w_ofs_y;
                n_step  = tcbr_pkg::STEP_EC;
            end
            tcbr_pkg::STEP_EC: begin
                n_step  = tcbr_pkg::STEP_D_X;
            end
            default: begin
                n_step  = tcbr_pkg::STEP_D_X;
            end
        endcase
    end

    assign w_prod     = w_mul_a * w_mul_b;
    assign w_prod_ext = {{(tcbr_pkg::EDGE_W - tcbr_pkg::PROD_W){w_prod[tcbr_pkg::PROD_W-1]}},
                         w_prod};

    // inclusive inside test against the sign of the denominator
    assign w_d_pos = !r_d[tcbr_pkg::EDGE_W-1];
    always_comb begin
        if (w_d_pos) begin
            w_inside = !r_ea[tcbr_pkg::EDGE_W-1] && !r_eb[tcbr_pkg::EDGE_W-1]
                    && !r_ec[tcbr_pkg::EDGE_W-1];
        end else begin
            w_inside = (r_ea[tcbr_pkg::EDGE_W-1] || (r_ea == '0))
                    && (r_eb[tcbr_pkg::EDGE_W-1] || (r_eb == '0))
                    && (r_ec[tcbr_pkg::EDGE_W-1] || (r_ec == '0));
        end
    end

    assign w_in_grid  = (r_px < tcbr_pkg::PIX_W'(PIXELS_PER_SIDE))
                     && (r_py < tcbr_pkg::PIX_W'(PIXELS_PER_SIDE));
    assign w_row_end  = (r_i == CNT_W'(BIN_SIZE - 1));
    assign w_last_row = (r_j == CNT_W'(BIN_SIZE - 1));

    // count * 255 / 256, saturated
    assign w_scaled  = {r_count, tcbr_pkg::FRAC_SHIFT'(0)} - SCALE_W'(r_count);
    assign w_cov_ext = SCALE_W'(w_scaled[SCALE_W-1:tcbr_pkg::FRAC_SHIFT]);
    assign w_cov     = (w_cov_ext > SCALE_W'(tcbr_pkg::COV_MAX))
                     ? tcbr_pkg::COV_W'(tcbr_pkg::COV_MAX)
                     : w_cov_ext[tcbr_pkg::COV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= tcbr_pkg::STEP_D_X;
            r_out_valid <= 1'b0;
        end else begin
            // output register loads from the finish state, else drains independently
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_cx     <= i_vertex_c_x;
                        r_cy     <= i_vertex_c_y;
                        r_px0    <= tcbr_pkg::PIX_W'(i_bin_col) * tcbr_pkg::PIX_W'(BIN_SIZE);
                        r_py0    <= tcbr_pkg::PIX_W'(i_bin_row) * tcbr_pkg::PIX_W'(BIN_SIZE);
                        r_bin_ok <= (BCMP_W'(i_bin_col) < BCMP_W'(BINS_PER_SIDE))
                                 && (BCMP_W'(i_bin_row) < BCMP_W'(BINS_PER_SIDE));
                        r_ka_x   <= $signed({1'b0, i_vertex_b_y}) - $signed({1'b0, i_vertex_c_y});
                        r_ka_y   <= $signed({1'b0, i_vertex_c_x}) - $signed({1'b0, i_vertex_b_x});
                        r_kb_x   <= $signed({1'b0, i_vertex_c_y}) - $signed({1'b0, i_vertex_a_y});
                        r_kb_y   <= $signed({1'b0, i_vertex_a_x}) - $signed({1'b0, i_vertex_c_x});
                        r_kc_x   <= $signed({1'b0, i_vertex_a_y}) - $signed({1'b0, i_vertex_b_y});
                        r_kc_y   <= $signed({1'b0, i_vertex_b_x}) - $signed({1'b0, i_vertex_a_x});
                        r_d      <= '0;
                        r_ea     <= '0;
                        r_eb     <= '0;
                        r_step   <= tcbr_pkg::STEP_D_X;
                        r_state  <= S_SETUP;
                    end
                end

                S_SETUP: begin
                    r_step <= n_step;
                    case (r_step)
                        tcbr_pkg::STEP_D_X,
                        tcbr_pkg::STEP_D_Y: begin
                            r_d <= r_d + w_prod_ext;
                        end
                        tcbr_pkg::STEP_EA_X,
                        tcbr_pkg::STEP_EA_Y: begin
                            r_ea <= r_ea + w_prod_ext;
                        end
                        tcbr_pkg::STEP_EB_X,
                        tcbr_pkg::STEP_EB_Y: begin
                            r_eb <= r_eb + w_prod_ext;
                        end
                        tcbr_pkg::STEP_EC: begin
                            // edge c from the denominator minus edges a and b, then start the walk
                            r_ec     <= r_d - r_ea - r_eb;
                            r_ec_row <= r_d - r_ea - r_eb;
                            r_ea_row <= r_ea;
                            r_eb_row <= r_eb;
                            r_active <= r_bin_ok && (r_d != '0);
                            r_i      <= '0;
                            r_j      <= '0;
                            r_px     <= r_px0;
                            r_py     <= r_py0;
                            r_count  <= '0;
                            r_state  <= S_SCAN;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end

                S_SCAN: begin
                    if (r_active && w_in_grid && w_inside) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                    if (w_row_end) begin
                        // back to the start of the row, one row down
                        r_i      <= '0;
                        r_j      <= r_j + CNT_W'(1);
                        r_px     <= r_px0;
                        r_py     <= r_py + tcbr_pkg::PIX_W'(1);
                        r_ea     <= r_ea_row + tcbr_pkg::EDGE_W'(r_ka_y);
                        r_eb     <= r_eb_row + tcbr_pkg::EDGE_W'(r_kb_y);
                        r_ec     <= r_ec_row + tcbr_pkg::EDGE_W'(r_kc_y);
                        r_ea_row <= r_ea_row + tcbr_pkg::EDGE_W'(r_ka_y);
                        r_eb_row <= r_eb_row + tcbr_pkg::EDGE_W'(r_kb_y);
                        r_ec_row <= r_ec_row + tcbr_pkg::EDGE_W'(r_kc_y);
                        if (w_last_row) begin
                            r_state <= S_FINISH;
                        end
                    end else begin
                        r_i  <= r_i + CNT_W'(1);
                        r_px <= r_px + tcbr_pkg::PIX_W'(1);
                        r_ea <= r_ea + tcbr_pkg::EDGE_W'(r_ka_x);
                        r_eb <= r_eb + tcbr_pkg::EDGE_W'(r_kb_x);
                        r_ec <= r_ec + tcbr_pkg::EDGE_W'(r_kc_x);
                    end
                end

                S_FINISH: begin
                    // wait here only while an older result is still stalled
                    if (w_out_load) begin
                        r_coverage  <= w_cov;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
